// ===== src/mamm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mamm_pkg;

  localparam int unsigned LIMB_W  = 64;
  localparam int unsigned HALF_W  = LIMB_W / 2;
  localparam int unsigned WIDE_W  = 2 * LIMB_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONT_FACTOR  = 2'd2;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [WIDE_W-1:0] wide_t;

endpackage
`default_nettype wire

// ===== src/mamm_mul64.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-stage 64 x 64 multiplier: four 32 x 32 partial products, then their sum.
module mamm_mul64 (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire mamm_pkg::limb_t a_i,
  input  wire mamm_pkg::limb_t b_i,
  output mamm_pkg::wide_t     prod_o
);
  import mamm_pkg::*;

  limb_t pp00_q, pp01_q, pp10_q, pp11_q;
  wide_t prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= a_i[HALF_W-1:0] * b_i[HALF_W-1:0];
      pp01_q <= a_i[HALF_W-1:0] * b_i[LIMB_W-1:HALF_W];
      pp10_q <= a_i[LIMB_W-1:HALF_W] * b_i[HALF_W-1:0];
      pp11_q <= a_i[LIMB_W-1:HALF_W] * b_i[LIMB_W-1:HALF_W];
      prod_q <= {{LIMB_W{1'b0}}, pp00_q}
              + {{HALF_W{1'b0}}, pp01_q, {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, pp10_q, {HALF_W{1'b0}}}
              + {pp11_q, {LIMB_W{1'b0}}};
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== src/modular_add_montgomery_mul_128.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 128-bit modular adder and Montgomery multiplier over a configured modulus. Each transaction
// carries a mode in tuser and two operands in tdata; mode 0 returns (a + b) reduced once,
// mode 1 returns a * b * 2^-128 mod p in two word passes with one final subtraction. The
// pipeline is sixteen stages deep and takes a new transaction every cycle unless the output
// stalls; its depth is set by the chain of five dependent 64-bit multiplications, each built
// from 32 x 32 partial products over two stages. A stall on the output freezes the whole
// pipeline. Configuration is to be written only while the pipeline is empty.
module modular_add_montgomery_mul_128 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mamm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire mamm_pkg::limb_t               cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_high, a_low, b_high, b_low
  input  wire logic [4*mamm_pkg::LIMB_W-1:0] s_axis_tdata,
  // mode
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // result_high, result_low
  output logic [2*mamm_pkg::LIMB_W-1:0]      m_axis_tdata
);
  import mamm_pkg::*;

  localparam int unsigned LAST = 16;

  limb_t mod_high_q, mod_low_q, factor_q;
  wide_t modulus;
  logic  en;
  logic [LAST:1] v_q;

  limb_t a_high, a_low, b_high, b_low;
  wide_t p00_w, p01_w, p10_w, p11_w, t1_w, tml1_w, tmh1_w, t2_w, tml2_w, tmh2_w;

  wide_t          p00_q [3:6];
  wide_t          p01_q [3:7];
  wide_t          p10_q [3:8];
  wide_t          p11_q [3:13];
  wide_t          sum_q [1:15];
  logic           mode_q [1:15];
  wide_t          tmh1_q, zq8_q, u9_q, a14_q, hl15_q, res16_q;
  logic [WIDE_W:0] s7_q;
  limb_t          z_q [9:14];
  wide_t          u_q [10:13];
  logic [LIMB_W:0] w14_q;
  logic [WIDE_W:0] w14_full;
  wide_t          pre_red;

  assign a_high  = s_axis_tdata[LIMB_W-1:0];
  assign a_low   = s_axis_tdata[2*LIMB_W-1:LIMB_W];
  assign b_high  = s_axis_tdata[3*LIMB_W-1:2*LIMB_W];
  assign b_low   = s_axis_tdata[4*LIMB_W-1:3*LIMB_W];
  assign modulus = {mod_high_q, mod_low_q};

  assign en            = !v_q[LAST] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[LAST];
  assign m_axis_tdata  = {res16_q[LIMB_W-1:0], res16_q[WIDE_W-1:LIMB_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_high_q <= '0;
      mod_low_q  <= limb_t'(1);
      factor_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS_HIGH: mod_high_q <= cfg_data_i;
        CFG_MODULUS_LOW:  mod_low_q  <= cfg_data_i;
        CFG_MONT_FACTOR:  factor_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:1], s_axis_tvalid};
    end
  end

  // Products of the operand limbs, all independent of each other.
  mamm_mul64 u_mul_p00 (.clk_i, .en_i(en), .a_i(a_low),  .b_i(b_low),  .prod_o(p00_w));
  mamm_mul64 u_mul_p01 (.clk_i, .en_i(en), .a_i(a_low),  .b_i(b_high), .prod_o(p01_w));
  mamm_mul64 u_mul_p10 (.clk_i, .en_i(en), .a_i(a_high), .b_i(b_low),  .prod_o(p10_w));
  mamm_mul64 u_mul_p11 (.clk_i, .en_i(en), .a_i(a_high), .b_i(b_high), .prod_o(p11_w));

  // First word pass.
  mamm_mul64 u_mul_t1 (.clk_i, .en_i(en), .a_i(p00_w[LIMB_W-1:0]), .b_i(factor_q),
                       .prod_o(t1_w));
  mamm_mul64 u_mul_tml1 (.clk_i, .en_i(en), .a_i(t1_w[LIMB_W-1:0]), .b_i(mod_low_q),
                         .prod_o(tml1_w));
  mamm_mul64 u_mul_tmh1 (.clk_i, .en_i(en), .a_i(t1_w[LIMB_W-1:0]), .b_i(mod_high_q),
                         .prod_o(tmh1_w));

  // Second word pass.
  mamm_mul64 u_mul_t2 (.clk_i, .en_i(en), .a_i(u9_q[LIMB_W-1:0]), .b_i(factor_q),
                       .prod_o(t2_w));
  mamm_mul64 u_mul_tml2 (.clk_i, .en_i(en), .a_i(t2_w[LIMB_W-1:0]), .b_i(mod_low_q),
                         .prod_o(tml2_w));
  mamm_mul64 u_mul_tmh2 (.clk_i, .en_i(en), .a_i(t2_w[LIMB_W-1:0]), .b_i(mod_high_q),
                         .prod_o(tmh2_w));

  assign w14_full = {1'b0, u_q[13]} + {1'b0, tml2_w};
  assign pre_red  = (mode_q[15] == MODE_MUL) ? hl15_q : sum_q[15];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q[1]  <= {a_high, a_low} + {b_high, b_low};
      mode_q[1] <= s_axis_tuser;
      for (int i = 2; i <= 15; i++) begin
        sum_q[i]  <= sum_q[i-1];
        mode_q[i] <= mode_q[i-1];
      end
      p00_q[3] <= p00_w;
      for (int i = 4; i <= 6; i++) p00_q[i] <= p00_q[i-1];
      p01_q[3] <= p01_w;
      for (int i = 4; i <= 7; i++) p01_q[i] <= p01_q[i-1];
      p10_q[3] <= p10_w;
      for (int i = 4; i <= 8; i++) p10_q[i] <= p10_q[i-1];
      p11_q[3] <= p11_w;
      for (int i = 4; i <= 13; i++) p11_q[i] <= p11_q[i-1];

      // The upper 65 bits of this sum are the carry and q of the first pass.
      s7_q   <= {1'b0, p00_q[6]} + {1'b0, tml1_w};
      tmh1_q <= tmh1_w;
      // z sits in the upper limb, q in the lower.
      zq8_q  <= {{(LIMB_W-1){1'b0}}, s7_q[WIDE_W:LIMB_W]} + p01_q[7] + tmh1_q;
      u9_q   <= p10_q[8] + {{LIMB_W{1'b0}}, zq8_q[LIMB_W-1:0]};
      z_q[9] <= zq8_q[WIDE_W-1:LIMB_W];
      for (int i = 10; i <= 14; i++) z_q[i] <= z_q[i-1];
      u_q[10] <= u9_q;
      for (int i = 11; i <= 13; i++) u_q[i] <= u_q[i-1];

      w14_q  <= w14_full[WIDE_W:LIMB_W];
      a14_q  <= p11_q[13] + tmh2_w;
      hl15_q <= a14_q + {{LIMB_W{1'b0}}, z_q[14]} + {{(LIMB_W-1){1'b0}}, w14_q};
      res16_q <= (pre_red >= modulus) ? pre_red - modulus : pre_red;
    end
  end

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s_axis_tvalid |=> v_q[1])
    else $error("accepted transaction did not enter the pipeline");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[8] |=> v_q[9])
    else $error("valid bit lost in the middle of the pipeline");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q) && $stable(res16_q))
    else $error("pipeline moved during an output stall");

endmodule
`default_nettype wire

// ===== tb/sv/modular_add_montgomery_mul_128_tb.sv =====
`timescale 1ns / 1ps
module modular_add_montgomery_mul_128_tb;
  import mamm_pkg::*;

  typedef struct {
    logic  mode;
    limb_t ah, al, bh, bl;
    bit    fixed;
    limb_t eh, el;
  } operand_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  limb_t                  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [4*LIMB_W-1:0]    s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [2*LIMB_W-1:0]    m_axis_tdata;

  modular_add_montgomery_mul_128 u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the configuration registers, updated as the block sees the writes.
  limb_t mod_high = '0;
  limb_t mod_low = 64'd1;
  limb_t mont_factor = '0;

  operand_row_t offered_q[$];
  wide_t        residue_q[$];
  operand_row_t directed_rows[$];
  int unsigned  n_errors = 0;
  int unsigned  idle_cycles = 0;
  bit           rx_quiet = 1'b0;
  bit           hold_start = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  rx_wait = 0;

  task automatic report_mismatch(string what, limb_t got, limb_t want);
    n_errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic wide_t wmul(limb_t x, limb_t y);
    return wide_t'(x) * wide_t'(y);
  endfunction

  function automatic logic [LIMB_W:0] add3(limb_t x, limb_t y, logic cin);
    return {1'b0, x} + {1'b0, y} + {{LIMB_W{1'b0}}, cin};
  endfunction

  function automatic wide_t reduce_mod(wide_t v);
    wide_t p;
    p = {mod_high, mod_low};
    return (v >= p) ? v - p : v;
  endfunction

  function automatic wide_t montgomery_product(limb_t x1, limb_t x0, limb_t y1, limb_t y0);
    wide_t pr, tp;
    logic [LIMB_W:0] s;
    limb_t t, q, z, u0, u1, h, l;
    logic e;
    // First word pass over the low limb of x.
    pr = wmul(x0, y0);
    t  = pr[63:0] * mont_factor;
    tp = wmul(t, mod_low);
    s  = add3(pr[63:0], tp[63:0], 1'b0);
    s  = add3(pr[127:64], tp[127:64], s[64]);
    q  = s[63:0];
    z  = limb_t'(s[64]);
    pr = wmul(x0, y1);
    s  = add3(q, pr[63:0], 1'b0);
    q  = s[63:0];
    z  = z + pr[127:64] + limb_t'(s[64]);
    tp = wmul(t, mod_high);
    s  = add3(q, tp[63:0], 1'b0);
    q  = s[63:0];
    z  = z + tp[127:64] + limb_t'(s[64]);
    // Second word pass over the high limb of x.
    pr = wmul(x1, y0);
    s  = add3(pr[63:0], q, 1'b0);
    u0 = s[63:0];
    u1 = pr[127:64] + limb_t'(s[64]);
    t  = u0 * mont_factor;
    tp = wmul(t, mod_low);
    s  = add3(u0, tp[63:0], 1'b0);
    s  = add3(u1, tp[127:64], s[64]);
    u1 = s[63:0];
    e  = s[64];
    pr = wmul(x1, y1);
    h  = pr[127:64];
    l  = pr[63:0];
    tp = wmul(t, mod_high);
    s  = add3(l, tp[63:0], 1'b0);
    l  = s[63:0];
    h  = h + tp[127:64] + limb_t'(s[64]);
    s  = add3(l, z, 1'b0);
    l  = s[63:0];
    h  = h + limb_t'(s[64]);
    s  = add3(l, u1, 1'b0);
    l  = s[63:0];
    h  = h + limb_t'(e) + limb_t'(s[64]);
    return reduce_mod({h, l});
  endfunction

  function automatic wide_t modular_result(operand_row_t r);
    if (r.mode == MODE_ADD) return reduce_mod({r.ah, r.al} + {r.bh, r.bl});
    return montgomery_product(r.ah, r.al, r.bh, r.bl);
  endfunction

  // Acceptance of operands, configuration writes and results, all at the clock edge.
  always @(posedge clk_i) begin
    operand_row_t r;
    wide_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_we_i) begin
        idle_cycles = 0;
        case (cfg_idx_i)
          CFG_MODULUS_HIGH: mod_high = cfg_data_i;
          CFG_MODULUS_LOW:  mod_low = cfg_data_i;
          CFG_MONT_FACTOR:  mont_factor = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        r = offered_q.pop_front();
        residue_q.push_back(r.fixed ? {r.eh, r.el} : modular_result(r));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (residue_q.size() == 0) begin
          report_mismatch("unexpected result_high", m_axis_tdata[63:0], '0);
        end else begin
          want = residue_q.pop_front();
          if (m_axis_tdata[63:0] !== want[127:64])
            report_mismatch("result_high", m_axis_tdata[63:0], want[127:64]);
          if (m_axis_tdata[127:64] !== want[63:0])
            report_mismatch("result_low", m_axis_tdata[127:64], want[63:0]);
        end
      end
      if (idle_cycles >= 5000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Result side: random stalls per transaction, plus an occasional long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_start) begin
        hold_left = 300;
        hold_start = 1'b0;
      end
      if (m_axis_tvalid && m_axis_tready) rx_wait = rx_quiet ? 0 : $urandom_range(0, 18);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic offer(operand_row_t r, int unsigned gap);
    offered_q.push_back(r);
    s_axis_tdata  <= {r.bl, r.bh, r.al, r.ah};
    s_axis_tuser  <= r.mode;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (residue_q.size() != 0 || offered_q.size() != 0) @(posedge clk_i);
  endtask

  // The write enable stays high; the caller drops it after the last write of a burst.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, limb_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  function automatic limb_t neg_inverse(limb_t p0);
    limb_t inv;
    inv = p0;
    repeat (5) inv = inv * (64'd2 - p0 * inv);
    return -inv;
  endfunction

  function automatic limb_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic wide_t pick_operand(wide_t p);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return p - 1;
      2, 3: return {rand64(), rand64()};
      default: return {rand64(), rand64()} % p;
    endcase
  endfunction

  function automatic operand_row_t row(logic mode, wide_t a, wide_t b);
    operand_row_t r;
    r.mode = mode;
    {r.ah, r.al} = a;
    {r.bh, r.bl} = b;
    r.fixed = 1'b0;
    r.eh = '0;
    r.el = '0;
    return r;
  endfunction

  function automatic operand_row_t fixed_row(logic mode, wide_t a, wide_t b, wide_t res);
    operand_row_t r;
    r = row(mode, a, b);
    r.fixed = 1'b1;
    {r.eh, r.el} = res;
    return r;
  endfunction

  initial begin
    wide_t ones, p, a, b;
    limb_t mh, ml, mf;
    int unsigned max_gap;
    ones = '1;
    // With the reset modulus of one, sums reduce by one at most and products with
    // a zero factor collapse to zero.
    directed_rows.push_back(fixed_row(MODE_ADD, '0, '0, '0));
    directed_rows.push_back(fixed_row(MODE_ADD, ones, ones, ones - 2));
    directed_rows.push_back(fixed_row(MODE_ADD, ones, 128'd1, '0));
    directed_rows.push_back(fixed_row(MODE_ADD, 128'd1, '0, '0));
    directed_rows.push_back(fixed_row(MODE_MUL, '0, '0, '0));
    directed_rows.push_back(fixed_row(MODE_MUL, '0, ones, '0));
    directed_rows.push_back(row(MODE_MUL, ones, ones));
    directed_rows.push_back(row(MODE_MUL, 128'd1, 128'd1));
    directed_rows.push_back(row(MODE_MUL, {64'd0, ones[63:0]}, {ones[63:0], 64'd0}));
    directed_rows.push_back(row(MODE_ADD, {ones[63:0], 64'd0}, {64'd0, ones[63:0]}));
    directed_rows.push_back(row(MODE_MUL, {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
                                {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555}));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) offer(directed_rows[i], $urandom_range(0, 3));
    drain();

    // Each phase sets a modulus: typical, at the bounds, small, even, or with a wrong factor.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin mh = rand64() >> 1; ml = rand64() | 1; end
        1: begin mh = 64'h7fff_ffff_ffff_ffff; ml = '1; end
        2: begin mh = '1; ml = '1; end
        3: begin mh = '0; ml = 64'd3; end
        4: begin mh = '0; ml = rand64() | 1; end
        5: begin mh = rand64(); ml = rand64() & ~64'd1; end
        6: begin mh = rand64(); ml = rand64() | 1; end
        7: begin mh = 64'h8000_0000_0000_0000; ml = 64'd1; end
        default: begin mh = rand64() >> $urandom_range(1, 63); ml = rand64() | 1; end
      endcase
      mf = (phase == 5 || phase == 6) ? rand64() : neg_inverse(ml);
      write_reg(CFG_MODULUS_HIGH, mh);
      write_reg(CFG_MODULUS_LOW, ml);
      write_reg(CFG_MONT_FACTOR, mf);
      // An index past the register list must leave the configuration alone.
      if (phase == 3) write_reg(2'd3, rand64());
      cfg_we_i <= 1'b0;
      p = {mh, ml};
      max_gap = (phase == 2) ? 0 : 18;
      rx_quiet = (phase == 2);
      for (int n = 0; n < 120; n++) begin
        if (phase == 4 && n == 5) hold_start = 1'b1;
        a = pick_operand(p);
        b = pick_operand(p);
        offer(row(logic'($urandom_range(0, 1)), a, b),
              (phase == 4 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap));
        if (n == 60) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
